>>> hw/rtl/rational_arithmetic_unit_defines.svh
// assertion macros used by the checker file
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rau check failed");

`endif

>>> hw/rtl/rau_pkg.sv
package rau_pkg;

   // result field width
   localparam int RES_WIDTH = 34;
   localparam int KIND_WIDTH = 3;

   // operation codes
   localparam logic [KIND_WIDTH-1:0] KIND_ADD  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SUB  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_MUL  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_DIV  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_NEG  = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_NORM = 3'd5;

   typedef logic signed [RES_WIDTH-1:0] res_type;

endpackage

>>> hw/rtl/rau_req_if.sv
interface rau_req_if #(
   parameter int OPERAND_WIDTH = 16
);
   logic valid;
   logic ready;
   logic [rau_pkg::KIND_WIDTH-1:0] kind;
   logic signed [OPERAND_WIDTH-1:0] a_num;
   logic signed [OPERAND_WIDTH-1:0] a_den;
   logic a_err;
   logic signed [OPERAND_WIDTH-1:0] b_num;
   logic signed [OPERAND_WIDTH-1:0] b_den;
   logic b_err;

   modport source (output valid, kind, a_num, a_den, a_err, b_num, b_den, b_err,
                   input ready);
   modport sink (input valid, kind, a_num, a_den, a_err, b_num, b_den, b_err,
                 output ready);
endinterface

>>> hw/rtl/rau_rsp_if.sv
interface rau_rsp_if;
   logic valid;
   logic ready;
   rau_pkg::res_type res_num;
   rau_pkg::res_type res_den;
   logic res_err;

   modport source (output valid, res_num, res_den, res_err, input ready);
   modport sink (input valid, res_num, res_den, res_err, output ready);
endinterface

>>> hw/rtl/rau_mul.sv
module rau_mul #(
   parameter int W = 16
) (
   input  logic clock,
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   output logic [2*W-1:0] prod_ff
);
   logic [2*W-1:0] prod_in;

   // unsigned magnitude product, registered
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

>>> hw/rtl/rau_gcd.sv
module rau_gcd #(
   parameter int MW = 33
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [MW-1:0] x,
   input  logic [MW-1:0] y,
   output logic done_ff,
   output logic [MW-1:0] g_ff
);
   localparam int KW = $clog2(MW + 1);

   logic busy_ff, busy_in;
   logic done_in;
   logic [MW-1:0] x_ff, x_in, y_ff, y_in, g_in;
   logic [KW-1:0] k_ff, k_in;

   // binary gcd, one shift or subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      g_in = g_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in = x;
         y_in = y;
         k_in = '0;
      end else if (busy_ff) begin
         if (x_ff == y_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            g_in = x_ff << k_ff;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end
endmodule

>>> hw/rtl/rau_div.sv
module rau_div #(
   parameter int MW = 33
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [MW-1:0] dividend,
   input  logic [MW-1:0] divisor,
   output logic done_ff,
   output logic [MW-1:0] quo_ff
);
   localparam int CW = $clog2(MW + 1);

   logic busy_ff, busy_in, done_in;
   logic [MW-1:0] rem_ff, rem_in, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW:0] trial;
   logic [MW:0] diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[MW-1]};
      diff = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CW'(MW);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[MW-1:0];
            quo_in = {quo_ff[MW-2:0], 1'b1};
         end else begin
            rem_in = trial[MW-1:0];
            quo_in = {quo_ff[MW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end
endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: one operation (add, subtract, multiply, divide,
// negate, normalize) per request on one or two fractions, one response each.
// One request is in flight at a time; req_ch.ready is high only while idle.
// Error cases, negate and normalize answer in the cycle after the request.
// Add, subtract, multiply and divide run three products through a single
// registered multiplier, a combine step, a binary gcd that takes one shift
// or subtract per cycle plus a done step, and two restoring divisions by the
// gcd; a zero numerator skips the reduction. The gcd and the two divisions
// take most of the time of a request.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   rau_req_if.sink req_ch,
   rau_rsp_if.source rsp_ch
);
   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * W + 1;
   localparam int EW = 2 * W + 2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3,
      ST_COMB, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [rau_pkg::KIND_WIDTH-1:0] kind_ff, kind_in;
   logic signed [W-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [2*W-1:0] t1_ff, t1_in, td_ff, td_in, t2_ff, t2_in;
   logic [MW-1:0] nmag_ff, nmag_in, dmag_ff, dmag_in, g_ff, g_in, qn_ff, qn_in;
   logic nneg_ff, nneg_in, dneg_ff, dneg_in;
   rau_pkg::res_type num_ff, num_in, den_ff, den_in;
   logic err_ff, err_in;

   logic [W-1:0] mul_a, mul_b;
   logic [2*W-1:0] prod;
   logic gcd_start, gcd_done, div_start, div_done;
   logic [MW-1:0] gcd_g, div_dividend, div_divisor, div_q;
   logic signed [EW-1:0] sum_c, t1_s, t2_s;
   logic [MW-1:0] nmag_c, dmag_c;
   logic nneg_c, dneg_c, addsub;

   function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   function automatic rau_pkg::res_type form(input logic neg, input logic [MW-1:0] m);
      logic signed [EW-1:0] s;
      s = signed'({1'b0, m});
      if (neg) begin
         s = -s;
      end
      return rau_pkg::RES_WIDTH'(s);
   endfunction

   function automatic rau_pkg::res_type ext(input logic signed [W-1:0] v,
                                           input logic neg);
      logic signed [EW-1:0] s;
      s = EW'(v);
      if (neg) begin
         s = -s;
      end
      return rau_pkg::RES_WIDTH'(s);
   endfunction

   rau_mul #(.W(W)) u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));

   rau_gcd #(.MW(MW)) u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start), .x(nmag_c), .y(dmag_c),
      .done_ff(gcd_done), .g_ff(gcd_g)
   );

   rau_div #(.MW(MW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done_ff(div_done), .quo_ff(div_q)
   );

   // multiplier operand select per step
   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_a = mag_of(an_ff);
            mul_b = (kind_ff == rau_pkg::KIND_MUL) ? mag_of(bn_ff) : mag_of(bd_ff);
         end
         ST_MUL1: begin
            mul_a = mag_of(ad_ff);
            mul_b = (kind_ff == rau_pkg::KIND_DIV) ? mag_of(bn_ff) : mag_of(bd_ff);
         end
         default: begin
            mul_a = mag_of(ad_ff);
            mul_b = mag_of(bn_ff);
         end
      endcase
   end

   // combine signed products into numerator and denominator
   always_comb begin
      addsub = (kind_ff == rau_pkg::KIND_ADD) || (kind_ff == rau_pkg::KIND_SUB);
      case (kind_ff)
         rau_pkg::KIND_MUL: nneg_c = an_ff[W-1] ^ bn_ff[W-1];
         rau_pkg::KIND_DIV: nneg_c = an_ff[W-1] ^ bd_ff[W-1] ^ bn_ff[W-1];
         default:           nneg_c = an_ff[W-1] ^ bd_ff[W-1];
      endcase
      dneg_c = (kind_ff == rau_pkg::KIND_DIV) ? ad_ff[W-1] : (ad_ff[W-1] ^ bd_ff[W-1]);
      t1_s = signed'({2'b00, t1_ff});
      if (nneg_c) begin
         t1_s = -t1_s;
      end
      t2_s = signed'({2'b00, t2_ff});
      if (ad_ff[W-1] ^ bn_ff[W-1] ^ (kind_ff == rau_pkg::KIND_SUB)) begin
         t2_s = -t2_s;
      end
      if (!addsub) begin
         t2_s = '0;
      end
      sum_c = t1_s + t2_s;
      nmag_c = sum_c[EW-1] ? MW'(-sum_c) : MW'(sum_c);
      dmag_c = {1'b0, td_ff};
   end

   assign gcd_start = (state_ff == ST_COMB) && (nmag_c != '0);
   assign div_start = ((state_ff == ST_GCD) && gcd_done) || ((state_ff == ST_DIVN) && div_done);
   assign div_dividend = (state_ff == ST_GCD) ? nmag_ff : dmag_ff;
   assign div_divisor = (state_ff == ST_GCD) ? gcd_g : g_ff;

   // sequencer
   always_comb begin
      logic in_err;
      logic b_used;
      state_in = state_ff;
      kind_in = kind_ff;
      an_in = an_ff;
      ad_in = ad_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      t1_in = t1_ff;
      td_in = td_ff;
      t2_in = t2_ff;
      nmag_in = nmag_ff;
      dmag_in = dmag_ff;
      nneg_in = nneg_ff;
      dneg_in = dneg_ff;
      g_in = g_ff;
      qn_in = qn_ff;
      num_in = num_ff;
      den_in = den_ff;
      err_in = err_ff;
      b_used = (req_ch.kind == rau_pkg::KIND_ADD) || (req_ch.kind == rau_pkg::KIND_SUB)
            || (req_ch.kind == rau_pkg::KIND_MUL) || (req_ch.kind == rau_pkg::KIND_DIV);
      in_err = (req_ch.kind > rau_pkg::KIND_NORM) || req_ch.a_err || (req_ch.a_den == '0)
            || (b_used && (req_ch.b_err || (req_ch.b_den == '0)))
            || ((req_ch.kind == rau_pkg::KIND_DIV) && (req_ch.b_num == '0));
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in = req_ch.kind;
               an_in = req_ch.a_num;
               ad_in = req_ch.a_den;
               bn_in = req_ch.b_num;
               bd_in = req_ch.b_den;
               num_in = '0;
               den_in = '0;
               err_in = 1'b0;
               if (in_err) begin
                  err_in = 1'b1;
                  state_in = ST_OUT;
               end else if (req_ch.kind == rau_pkg::KIND_NEG) begin
                  num_in = ext(req_ch.a_num, 1'b1);
                  den_in = ext(req_ch.a_den, 1'b0);
                  state_in = ST_OUT;
               end else if (req_ch.kind == rau_pkg::KIND_NORM) begin
                  num_in = ext(req_ch.a_num, req_ch.a_den[W-1]);
                  den_in = ext(req_ch.a_den, req_ch.a_den[W-1]);
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL0;
               end
            end
         end
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: begin
            t1_in = prod;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            td_in = prod;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            t2_in = prod;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            nmag_in = nmag_c;
            dmag_in = dmag_c;
            // sum sign for add and subtract, product sign otherwise
            nneg_in = addsub ? sum_c[EW-1] : nneg_c;
            dneg_in = dneg_c;
            if (nmag_c == '0) begin
               num_in = '0;
               den_in = form(dneg_c, dmag_c);
               state_in = ST_OUT;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               g_in = gcd_g;
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_done) begin
               qn_in = div_q;
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_done) begin
               num_in = form(nneg_ff, qn_ff);
               den_in = form(dneg_ff, div_q);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      an_ff <= an_in;
      ad_ff <= ad_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      t1_ff <= t1_in;
      td_ff <= td_in;
      t2_ff <= t2_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      g_ff <= g_in;
      qn_ff <= qn_in;
      num_ff <= num_in;
      den_ff <= den_in;
      err_ff <= err_in;
   end

   // channel handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = (state_ff == ST_OUT);
   assign rsp_ch.res_num = num_ff;
   assign rsp_ch.res_den = den_ff;
   assign rsp_ch.res_err = err_ff;
endmodule

>>> hw/rtl/rau_checker.sv
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rau_pkg::res_type rsp_num,
   input rau_pkg::res_type rsp_den,
   input logic rsp_err
);
   // one request in flight
   `RAU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `RAU_ASSERT_IMPLY(a_no_overlap, clock, reset, req_ready, !rsp_valid)
   // error response carries zero fraction
   `RAU_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_err, (rsp_num == '0) && (rsp_den == '0))
   // stalled response holds
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_num))
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_num(rsp_ch.res_num),
   .rsp_den(rsp_ch.res_den),
   .rsp_err(rsp_ch.res_err)
);
